@@ sv/qmj_pkg.sv @@
// Shared types and constants of the minimum-jerk quintic coefficient block.
package qmj_pkg;

	localparam int VAL_W = 48;
	localparam int DUR_W = 24;
	localparam int ST_W  = 2;
	localparam int QUO_W = VAL_W + 1;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic                    zero;
		logic signed [VAL_W-1:0] c0;
		logic signed [VAL_W-1:0] c1;
		logic signed [VAL_W-1:0] c2;
	} base_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/qmj_ifs.sv @@
// Channel interfaces: trajectory request and coefficient response.
interface qmj_req_if;
	import qmj_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] start_pos;
	logic signed [VAL_W-1:0] start_vel;
	logic signed [VAL_W-1:0] start_acc;
	logic signed [VAL_W-1:0] end_pos;
	logic signed [VAL_W-1:0] end_vel;
	logic signed [VAL_W-1:0] end_acc;
	logic [DUR_W-1:0]        duration;

	modport source (output valid, start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
		duration, input ready);
	modport sink (input valid, start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
		duration, output ready);
endinterface

interface qmj_rsp_if;
	import qmj_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] coef0;
	logic signed [VAL_W-1:0] coef1;
	logic signed [VAL_W-1:0] coef2;
	logic signed [VAL_W-1:0] coef3;
	logic signed [VAL_W-1:0] coef4;
	logic signed [VAL_W-1:0] coef5;
	logic [ST_W-1:0]         status;

	modport source (output valid, coef0, coef1, coef2, coef3, coef4, coef5, status,
		input ready);
	modport sink (input valid, coef0, coef1, coef2, coef3, coef4, coef5, status,
		output ready);
endinterface

@@ sv/qmj_front.sv @@
// Front end: accept a request, form the scaled boundary terms and numerators.
module qmj_front #(
	parameter int FRAC_BITS = 16,
	parameter int B0W = 116,
	parameter int B1W = 91,
	parameter int NW = 122
) (
	input  logic                              clk,
	input  logic                              arst_n,
	qmj_req_if.sink                           req,
	input  qmj_pkg::q_stat_t                  qs,
	output logic                              push,
	output logic signed [NW-1:0]              n3,
	output logic signed [NW-1:0]              n4,
	output logic signed [NW-1:0]              n5,
	output logic [3*qmj_pkg::DUR_W-1:0]       d3,
	output logic [4*qmj_pkg::DUR_W-1:0]       d4,
	output logic [5*qmj_pkg::DUR_W-1:0]       d5,
	output qmj_pkg::base_t                    base
);
	import qmj_pkg::*;

	localparam int DW  = VAL_W + 1;
	localparam int DDW = 2*DUR_W + 1;
	localparam int UW  = B1W + DUR_W;

	logic fe;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic              sa_neg;
	logic signed [DW-1:0] sa_ext;
	logic [DW-1:0]     sa_mag, sa_half;
	base_t             base_in;

	logic [DUR_W-1:0]        d_s1, d_s2, d_s3, d_s4, d_s5, d_s6;
	base_t                   base_s1, base_s2, base_s3, base_s4;
	base_t                   base_s5, base_s6, base_s7, base_s8;
	logic signed [VAL_W-1:0] sv_s1, sa_s1;
	logic signed [DW-1:0]    dp_s1, dv_s1, da_s1, dp_s2, dv_s2, dp_s3, dv_s3;
	logic signed [DDW-1:0]   dd_s2;
	logic signed [VAL_W+DUR_W-1:0]   svd_s3, sad_s3;
	logic signed [DW+DUR_W-1:0]      dad_s3;
	logic signed [DDW+DUR_W-1:0]     d3p_s4;
	logic signed [B0W-1:0]           b0p_s4, b0p_s5, b0_s6;
	logic signed [B1W-1:0]           b1_s4;
	logic signed [VAL_W+2*DUR_W-1:0] sadd_s5;
	logic signed [DW+2*DUR_W-1:0]    vt_s5, vt_s6;
	logic signed [UW-1:0]            u_s6;
	logic signed [DDW+2*DUR_W-1:0]   d4p_s6;
	logic signed [DDW+3*DUR_W-1:0]   d5p_s8;
	logic [3*DUR_W-1:0]              d3_s5, d3_s6, d3_s7, d3_s8;
	logic [4*DUR_W-1:0]              d4_s7, d4_s8;
	logic signed [NW-1:0]            n3_s7, n4_s7, n5_s7, n3_s8, n4_s8, n5_s8;
	logic signed [NW-1:0]            b0x, ux, vx;

	// hold the whole front while its last stage waits on a full queue
	assign fe        = !v_s8 || !qs.full;
	assign req.ready = fe;
	assign push      = v_s8 && !qs.full;

	always_comb begin
		sa_neg       = req.start_acc[VAL_W-1];
		sa_ext       = DW'(req.start_acc);
		sa_mag       = sa_neg ? DW'(-sa_ext) : DW'(sa_ext);
		sa_half      = (sa_mag + DW'(1)) >> 1;
		base_in.zero = (req.duration == '0);
		base_in.c0   = req.start_pos;
		base_in.c1   = req.start_vel;
		base_in.c2   = sa_neg ? -sa_half[VAL_W-1:0] : sa_half[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (fe) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// products by the duration, two stages each
	qmj_mul #(.AW(VAL_W)) u_mul_svd (
		.clk(clk), .en(fe), .a(sv_s1), .b(d_s1), .p(svd_s3)
	);
	qmj_mul #(.AW(VAL_W)) u_mul_sad (
		.clk(clk), .en(fe), .a(sa_s1), .b(d_s1), .p(sad_s3)
	);
	qmj_mul #(.AW(DW)) u_mul_dad (
		.clk(clk), .en(fe), .a(da_s1), .b(d_s1), .p(dad_s3)
	);
	qmj_mul #(.AW(DDW)) u_mul_d3 (
		.clk(clk), .en(fe), .a(dd_s2), .b(d_s2), .p(d3p_s4)
	);
	qmj_mul #(.AW(VAL_W+DUR_W)) u_mul_sadd (
		.clk(clk), .en(fe), .a(sad_s3), .b(d_s3), .p(sadd_s5)
	);
	qmj_mul #(.AW(DW+DUR_W)) u_mul_vt (
		.clk(clk), .en(fe), .a(dad_s3), .b(d_s3), .p(vt_s5)
	);
	qmj_mul #(.AW(B1W)) u_mul_u (
		.clk(clk), .en(fe), .a(b1_s4), .b(d_s4), .p(u_s6)
	);
	qmj_mul #(.AW(DDW+DUR_W)) u_mul_d4 (
		.clk(clk), .en(fe), .a(d3p_s4), .b(d_s4), .p(d4p_s6)
	);
	qmj_mul #(.AW(DDW+2*DUR_W)) u_mul_d5 (
		.clk(clk), .en(fe), .a(d4p_s6), .b(d_s6), .p(d5p_s8)
	);

	always_comb begin
		b0x = NW'(b0_s6);
		ux  = NW'(u_s6);
		vx  = NW'(vt_s6);
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			// differences of end and start
			d_s1    <= req.duration;
			base_s1 <= base_in;
			sv_s1   <= req.start_vel;
			sa_s1   <= req.start_acc;
			dp_s1   <= DW'(req.end_pos) - DW'(req.start_pos);
			dv_s1   <= DW'(req.end_vel) - DW'(req.start_vel);
			da_s1   <= DW'(req.end_acc) - DW'(req.start_acc);
			// square of the duration
			d_s2    <= d_s1;
			base_s2 <= base_s1;
			dp_s2   <= dp_s1;
			dv_s2   <= dv_s1;
			dd_s2   <= DDW'(d_s1) * DDW'(d_s1);
			// wait for the first products
			d_s3    <= d_s2;
			base_s3 <= base_s2;
			dp_s3   <= dp_s2;
			dv_s3   <= dv_s2;
			// partial b0, b1
			d_s4    <= d_s3;
			base_s4 <= base_s3;
			b0p_s4  <= (B0W'(dp_s3) <<< (2*FRAC_BITS+1)) - (B0W'(svd_s3) <<< (FRAC_BITS+1));
			b1_s4   <= (B1W'(dv_s3) <<< FRAC_BITS) - B1W'(sad_s3);
			d_s5    <= d_s4;
			base_s5 <= base_s4;
			b0p_s5  <= b0p_s4;
			d3_s5   <= d3p_s4[3*DUR_W-1:0];
			// finish b0
			d_s6    <= d_s5;
			base_s6 <= base_s5;
			b0_s6   <= b0p_s5 - B0W'(sadd_s5);
			vt_s6   <= vt_s5;
			d3_s6   <= d3_s5;
			// numerators of the three high coefficients
			base_s7 <= base_s6;
			n3_s7   <= (b0x * 10) - (ux <<< 3) + vx;
			n4_s7   <= (ux * 14) - (b0x * 15) - (vx <<< 1);
			n5_s7   <= (b0x * 6) - (ux * 6) + vx;
			d3_s7   <= d3_s6;
			d4_s7   <= d4p_s6[4*DUR_W-1:0];
			// hold the numerators for the fifth power
			base_s8 <= base_s7;
			n3_s8   <= n3_s7;
			n4_s8   <= n4_s7;
			n5_s8   <= n5_s7;
			d3_s8   <= d3_s7;
			d4_s8   <= d4_s7;
		end
	end

	assign n3   = n3_s8;
	assign n4   = n4_s8;
	assign n5   = n5_s8;
	assign d3   = d3_s8;
	assign d4   = d4_s8;
	assign d5   = d5p_s8[5*DUR_W-1:0];
	assign base = base_s8;

endmodule

// Multiply by the duration: slice products are registered first, their sum next.
module qmj_mul #(
	parameter int AW = 48
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [AW-1:0]                 a,
	input  logic [qmj_pkg::DUR_W-1:0]            b,
	output logic signed [AW+qmj_pkg::DUR_W-1:0] p
);
	import qmj_pkg::*;

	localparam int NS  = (AW + DUR_W - 1) / DUR_W;
	localparam int XW  = NS * DUR_W;
	localparam int PPW = 2 * DUR_W;
	localparam int PW  = AW + DUR_W;

	logic signed [XW-1:0] ax;
	logic signed [PPW:0]  pp_s1 [0:NS-1];
	logic signed [PW-1:0] sum;
	logic signed [PW-1:0] prod_s2;

	always_comb begin
		ax  = XW'(a);
		sum = '0;
		for (int i = 0; i < NS; i++) begin
			sum = sum + (PW'(pp_s1[i]) <<< (i * DUR_W));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// low slices are unsigned, the top slice carries the sign
			for (int i = 0; i < NS - 1; i++) begin
				pp_s1[i] <= $signed({1'b0, PPW'(ax[i*DUR_W +: DUR_W]) * PPW'(b)});
			end
			pp_s1[NS-1] <= $signed(ax[XW-1 -: DUR_W]) * $signed({1'b0, b});
			prod_s2     <= sum;
		end
	end

	assign p = prod_s2;

endmodule

@@ sv/qmj_fifo.sv @@
// Small flop queue between front and back end.
module qmj_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     wdata,
	input  logic             pop,
	output logic [W-1:0]     rdata,
	output qmj_pkg::q_stat_t qs
);
	import qmj_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = AW + 1;

	logic [W-1:0]    mem_q [0:DEPTH-1];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH-1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop) rd_q <= nxt(rd_q);
			if (push && !pop) cnt_q <= cnt_q + CNTW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	assign rdata    = mem_q[rd_q];
	assign qs.full  = (cnt_q == CNTW'(DEPTH));
	assign qs.empty = (cnt_q == '0);

endmodule

@@ sv/qmj_back.sv @@
// Back end: pipelined restoring division, rounding, saturation, output register.
module qmj_back #(
	parameter int FRAC_BITS = 16,
	parameter int NW = 122,
	parameter int CW = 235
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qmj_pkg::q_stat_t            qs,
	output logic                        pop,
	input  logic signed [NW-1:0]        n3,
	input  logic signed [NW-1:0]        n4,
	input  logic signed [NW-1:0]        n5,
	input  logic [3*qmj_pkg::DUR_W-1:0] d3,
	input  logic [4*qmj_pkg::DUR_W-1:0] d4,
	input  logic [5*qmj_pkg::DUR_W-1:0] d5,
	input  qmj_pkg::base_t              base,
	qmj_rsp_if.source                   rsp
);
	import qmj_pkg::*;

	localparam int NL = 3;
	localparam int DW = 5*DUR_W + 1;
	localparam logic [QUO_W-1:0] LIM_POS = QUO_W'((49'd1 << (VAL_W-1)) - 49'd1);
	localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(49'd1 << (VAL_W-1));

	logic be;

	logic signed [NW-1:0] nsel [0:NL-1];
	logic [DW-1:0]        dsel [0:NL-1];
	logic [NW-1:0]        absn [0:NL-1];

	logic          v_s1;
	base_t         base_s1;
	logic [CW-1:0] mag_s1 [0:NL-1];
	logic [DW-1:0] den_s1 [0:NL-1];
	logic          neg_s1 [0:NL-1];

	logic             v_d    [0:QUO_W];
	base_t            base_d [0:QUO_W];
	logic [CW-1:0]    rem_d  [0:QUO_W][0:NL-1];
	logic [QUO_W-1:0] quo_d  [0:QUO_W][0:NL-1];
	logic [DW-1:0]    den_d  [0:QUO_W][0:NL-1];
	logic             neg_d  [0:QUO_W][0:NL-1];
	logic             sat_d  [0:QUO_W][0:NL-1];

	logic [CW-1:0]    nrem [1:QUO_W][0:NL-1];
	logic [QUO_W-1:0] nquo [1:QUO_W][0:NL-1];
	logic [CW-1:0]    cmpv [1:QUO_W][0:NL-1];

	logic [QUO_W-1:0]        lim  [0:NL-1];
	logic                    satf [0:NL-1];
	logic [QUO_W-1:0]        qf   [0:NL-1];
	logic signed [VAL_W-1:0] cf   [0:NL-1];

	// advance everything whenever the output register can take a beat
	assign be  = !rsp.valid || rsp.ready;
	assign pop = be && !qs.empty;

	always_comb begin
		nsel[0] = n3;
		nsel[1] = n4;
		nsel[2] = n5;
		dsel[0] = DW'(d3);
		dsel[1] = DW'(d4);
		dsel[2] = DW'(d5);
		for (int l = 0; l < NL; l++) begin
			absn[l] = nsel[l][NW-1] ? NW'(-nsel[l]) : NW'(nsel[l]);
		end
	end

	always_comb begin
		for (int j = 1; j <= QUO_W; j++) begin
			for (int l = 0; l < NL; l++) begin
				cmpv[j][l] = CW'(den_d[j-1][l]) << (QUO_W - j + 1);
				if (rem_d[j-1][l] >= cmpv[j][l]) begin
					nrem[j][l] = rem_d[j-1][l] - cmpv[j][l];
					nquo[j][l] = quo_d[j-1][l] | (QUO_W'(1) << (QUO_W - j));
				end else begin
					nrem[j][l] = rem_d[j-1][l];
					nquo[j][l] = quo_d[j-1][l];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			lim[l]  = neg_d[QUO_W][l] ? LIM_NEG : LIM_POS;
			satf[l] = sat_d[QUO_W][l] || (quo_d[QUO_W][l] > lim[l]);
			qf[l]   = satf[l] ? lim[l] : quo_d[QUO_W][l];
			cf[l]   = neg_d[QUO_W][l] ? -qf[l][VAL_W-1:0] : qf[l][VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int j = 0; j <= QUO_W; j++) v_d[j] <= 1'b0;
			rsp.valid <= 1'b0;
		end else if (be) begin
			v_s1   <= !qs.empty;
			v_d[0] <= v_s1;
			for (int j = 1; j <= QUO_W; j++) v_d[j] <= v_d[j-1];
			rsp.valid <= v_d[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			// round: add the divisor power, divide by twice it
			base_s1 <= base;
			for (int l = 0; l < NL; l++) begin
				mag_s1[l] <= (CW'(absn[l]) << ((l + 1) * FRAC_BITS)) + CW'(dsel[l]);
				den_s1[l] <= dsel[l];
				neg_s1[l] <= nsel[l][NW-1];
			end
			// flag quotients that cannot fit before dividing
			base_d[0] <= base_s1;
			for (int l = 0; l < NL; l++) begin
				rem_d[0][l] <= mag_s1[l];
				quo_d[0][l] <= '0;
				den_d[0][l] <= den_s1[l];
				neg_d[0][l] <= neg_s1[l];
				sat_d[0][l] <= mag_s1[l] >= (CW'(den_s1[l]) << (QUO_W + 1));
			end
			for (int j = 1; j <= QUO_W; j++) begin
				base_d[j] <= base_d[j-1];
				for (int l = 0; l < NL; l++) begin
					rem_d[j][l] <= nrem[j][l];
					quo_d[j][l] <= nquo[j][l];
					den_d[j][l] <= den_d[j-1][l];
					neg_d[j][l] <= neg_d[j-1][l];
					sat_d[j][l] <= sat_d[j-1][l];
				end
			end
			// output register
			if (base_d[QUO_W].zero) begin
				rsp.coef0  <= '0;
				rsp.coef1  <= '0;
				rsp.coef2  <= '0;
				rsp.coef3  <= '0;
				rsp.coef4  <= '0;
				rsp.coef5  <= '0;
				rsp.status <= ST_ZERO;
			end else begin
				rsp.coef0  <= base_d[QUO_W].c0;
				rsp.coef1  <= base_d[QUO_W].c1;
				rsp.coef2  <= base_d[QUO_W].c2;
				rsp.coef3  <= cf[0];
				rsp.coef4  <= cf[1];
				rsp.coef5  <= cf[2];
				rsp.status <= (satf[0] || satf[1] || satf[2]) ? ST_SAT : ST_OK;
			end
		end
	end

endmodule

@@ sv/quintic_min_jerk_coefficients.sv @@
// Pipeline: 8 front stages, 1 queue slot, 2 set-up stages, 49 division stages, output register.
// Throughput: one beat per cycle while neither side stalls; each quotient bit has its own divider stage.
// Front and back stall apart; the queue absorbs QUEUE_DEPTH beats between them.
// Reset: arst_n clears valid flags, queue pointers and queue count only; no clearing pass.
module quintic_min_jerk_coefficients #(
	parameter int FRAC_BITS = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input logic       clk,
	input logic       arst_n,
	qmj_req_if.sink   req,
	qmj_rsp_if.source rsp
);
	import qmj_pkg::*;

	// internal widths follow the fraction width; sized for its whole range
	localparam int B0W = FRAC_BITS + 100;
	localparam int B1W = FRAC_BITS + 75;
	localparam int NW  = FRAC_BITS + 106;
	localparam int CW  = 4*FRAC_BITS + 171;
	localparam int QW  = 3*NW + 12*DUR_W + $bits(base_t);

	logic                   push, pop;
	q_stat_t                qs;
	logic signed [NW-1:0]   f_n3, f_n4, f_n5, b_n3, b_n4, b_n5;
	logic [3*DUR_W-1:0]     f_d3, b_d3;
	logic [4*DUR_W-1:0]     f_d4, b_d4;
	logic [5*DUR_W-1:0]     f_d5, b_d5;
	base_t                  f_base, b_base;
	logic [QW-1:0]          wdata, rdata;

	// classify and form numerators
	qmj_front #(
		.FRAC_BITS(FRAC_BITS),
		.B0W(B0W),
		.B1W(B1W),
		.NW(NW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.qs(qs),
		.push(push),
		.n3(f_n3),
		.n4(f_n4),
		.n5(f_n5),
		.d3(f_d3),
		.d4(f_d4),
		.d5(f_d5),
		.base(f_base)
	);

	assign wdata = {f_n3, f_n4, f_n5, f_d3, f_d4, f_d5, f_base};
	assign {b_n3, b_n4, b_n5, b_d3, b_d4, b_d5, b_base} = rdata;

	// decouple the two halves
	qmj_fifo #(
		.W(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(wdata),
		.pop(pop),
		.rdata(rdata),
		.qs(qs)
	);

	// divide, round, saturate and drive the response
	qmj_back #(
		.FRAC_BITS(FRAC_BITS),
		.NW(NW),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qs(qs),
		.pop(pop),
		.n3(b_n3),
		.n4(b_n4),
		.n5(b_n5),
		.d3(b_d3),
		.d4(b_d4),
		.d5(b_d5),
		.base(b_base),
		.rsp(rsp)
	);

endmodule

@@ tb/qmj_coef_checker.sv @@
// Passive checker: predicts the quintic coefficients of each request beat and compares responses.
module qmj_coef_checker (
	input  logic clk,
	input  logic arst_n,
	qmj_req_if   req,
	qmj_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	import qmj_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;

	typedef logic signed [255:0] big_t;

	typedef struct {
		logic signed [VAL_W-1:0] c[6];
		status_t                 st;
	} coefs_t;

	coefs_t coef_fifo[$];

	// Round num * 2^(m*FRAC) / (2 * d^k) to nearest, ties away from zero, then clamp.
	function automatic logic signed [VAL_W-1:0] round_clamp(big_t num, int m, int k,
			logic [DUR_W-1:0] d, output bit clipped);
		big_t mag, den, q, lim;
		bit   neg;
		neg = num < 0;
		mag = neg ? -num : num;
		mag = mag <<< (m * FRAC);
		den = 1;
		for (int i = 0; i < k; i++)
			den = den * big_t'(d);
		q = (mag + den) / (den <<< 1);
		lim = neg ? (big_t'(1) <<< 47) : ((big_t'(1) <<< 47) - 1);
		clipped = 0;
		if (q > lim) begin
			q = lim;
			clipped = 1;
		end
		q = neg ? -q : q;
		return q[VAL_W-1:0];
	endfunction

	function automatic coefs_t predict_coefs(logic signed [VAL_W-1:0] sp, sv, sa, ep, ev, ea,
			logic [DUR_W-1:0] d);
		coefs_t r;
		big_t bd, b0, b1, b2, u, v;
		logic [VAL_W:0] half;
		bit c3, c4, c5;
		if (d == 0) begin
			foreach (r.c[i]) r.c[i] = '0;
			r.st = ST_ZERO;
			return r;
		end
		bd = big_t'(d);
		r.c[0] = sp;
		r.c[1] = sv;
		// halve the start acceleration, ties away from zero
		half = sa < 0 ? -{sa[VAL_W-1], sa} : {sa[VAL_W-1], sa};
		half = (half + 1) >> 1;
		r.c[2] = sa < 0 ? -half[VAL_W-1:0] : half[VAL_W-1:0];
		b0 = ((big_t'(ep) - big_t'(sp)) <<< (2 * FRAC + 1)) - ((big_t'(sv) * bd) <<< (FRAC + 1))
			- big_t'(sa) * bd * bd;
		b1 = ((big_t'(ev) - big_t'(sv)) <<< FRAC) - big_t'(sa) * bd;
		b2 = big_t'(ea) - big_t'(sa);
		u = b1 * bd;
		v = b2 * bd * bd;
		r.c[3] = round_clamp(10 * b0 - 8 * u + v, 1, 3, d, c3);
		r.c[4] = round_clamp(14 * u - 15 * b0 - 2 * v, 2, 4, d, c4);
		r.c[5] = round_clamp(6 * b0 - 6 * u + v, 3, 5, d, c5);
		r.st = (c3 || c4 || c5) ? ST_SAT : ST_OK;
		return r;
	endfunction

	task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		$display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		coefs_t want;
		logic signed [VAL_W-1:0] got[6];
		if (!arst_n) begin
			coef_fifo.delete();
			errors = 0;
		end else begin
			if (req.valid && req.ready)
				coef_fifo.push_back(predict_coefs(req.start_pos, req.start_vel, req.start_acc,
					req.end_pos, req.end_vel, req.end_acc, req.duration));
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.coef0, rsp.coef1, rsp.coef2, rsp.coef3, rsp.coef4, rsp.coef5};
				if (coef_fifo.size() == 0) begin
					report("unexpected beat", '0, '0);
				end else begin
					want = coef_fifo.pop_front();
					foreach (got[i])
						if (got[i] !== want.c[i]) report($sformatf("coef%0d", i), got[i], want.c[i]);
					if (rsp.status !== want.st)
						report("status", VAL_W'(rsp.status), VAL_W'(want.st));
				end
			end
		end
		pending = coef_fifo.size();
	end

endmodule

@@ tb/quintic_min_jerk_coefficients_tb.sv @@
// Top of the testbench: clock, reset, request and response traffic, watchdog and verdict.
module quintic_min_jerk_coefficients_tb;
	import qmj_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;   // cycles without any beat before giving up
	localparam int HOLD_CYCLES = 1000;  // long receiver hold-off to fill the pipeline
	localparam int N_RANDOM = 2000;

	logic clk = 0;
	logic arst_n = 0;
	int   errors, pending;
	int   idle_cycles = 0;
	bit   stalls_on = 1;    // random gaps on both sides when set
	bit   hold_rsp = 0;     // ask the receiver for one long hold-off

	always #2 clk = ~clk;

	qmj_req_if req_ch ();
	qmj_rsp_if rsp_ch ();

	quintic_min_jerk_coefficients u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	qmj_coef_checker u_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.errors (errors),
		.pending(pending)
	);

	// Draw a 48-bit value whose magnitude is spread over every scale.
	function automatic logic signed [VAL_W-1:0] any_val();
		logic [63:0] r;
		logic signed [VAL_W-1:0] v;
		r = {$urandom, $urandom};
		v = r[VAL_W-1:0];
		if ($urandom_range(0, 3) == 0) return v;
		return v >>> $urandom_range(1, VAL_W - 1);
	endfunction

	function automatic logic [DUR_W-1:0] any_duration();
		logic [DUR_W-1:0] d;
		d = DUR_W'($urandom);
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return d >> $urandom_range(8, 23);
			default: return d >> $urandom_range(0, 7);  // mostly whole seconds and up
		endcase
	endfunction

	// Offer one beat after a random gap; hold valid high across back-to-back beats.
	task automatic send_beat(logic signed [VAL_W-1:0] sp, sv, sa, ep, ev, ea,
			logic [DUR_W-1:0] d);
		int gap;
		gap = stalls_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.start_pos <= sp;
		req_ch.start_vel <= sv;
		req_ch.start_acc <= sa;
		req_ch.end_pos   <= ep;
		req_ch.end_vel   <= ev;
		req_ch.end_acc   <= ea;
		req_ch.duration  <= d;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic send_random();
		send_beat(any_val(), any_val(), any_val(), any_val(), any_val(), any_val(),
			any_duration());
	endtask

	// Receiver: random stalls per beat, plus one long hold-off on request.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 0;
			end
			stall = stalls_on ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Watchdog: any cycle with no beat on either channel counts toward the limit.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL quintic_min_jerk_coefficients");
			$finish;
		end
	end

	localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] ONE  = 48'sh1_0000;

	initial begin
		req_ch.valid     <= 1'b0;
		req_ch.start_pos <= '0;
		req_ch.start_vel <= '0;
		req_ch.start_acc <= '0;
		req_ch.end_pos   <= '0;
		req_ch.end_vel   <= '0;
		req_ch.end_acc   <= '0;
		req_ch.duration  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero duration, tiny and huge durations, field extremes, rounding ties.
		send_beat(ONE, ONE, ONE, VMAX, VMIN, ONE, '0);
		send_beat('0, '0, '0, '0, '0, '0, '0);
		send_beat('0, '0, '0, '0, '0, '0, 24'h01_0000);
		send_beat('0, '0, '0, 10 * ONE, '0, '0, 24'h01_0000);
		send_beat('0, '0, '0, ONE, '0, '0, 24'h000001);
		send_beat('0, '0, '0, -ONE, '0, '0, 24'h000001);
		send_beat(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 24'hFF_FFFF);
		send_beat(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 24'hFF_FFFF);
		send_beat(VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, 24'h02_0000);
		send_beat(VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, 24'h000100);
		send_beat(-ONE, ONE, 48'sd1, 5 * ONE, '0, '0, 24'h03_0000);
		send_beat(ONE, -ONE, -48'sd1, -5 * ONE, ONE, ONE, 24'h04_8000);
		send_beat('0, '0, 48'sd3, ONE, '0, '0, 24'h00_8000);
		send_beat('0, '0, -48'sd3, -ONE, '0, '0, 24'hFF_0000);
		send_beat(2 * ONE, ONE / 2, -ONE, -2 * ONE, ONE, ONE / 4, 24'h07_0000);
		send_beat(VMAX, '0, '0, VMIN, '0, '0, 24'h7F_FFFF);
		send_beat('0, VMAX, '0, '0, VMIN, '0, 24'h80_0000);
		send_beat('0, '0, VMAX, '0, '0, VMIN, 24'h00_0001);

		// Random: back-to-back stretch, long receiver hold-off, drain pause.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 200) stalls_on = 0;
			if (n == 400) stalls_on = 1;
			if (n == 600) hold_rsp = 1;
			if (n == 1000) begin
				// drop valid so the last beat is not offered again while draining
				req_ch.valid <= 1'b0;
				wait (pending == 0);
			end
			send_random();
		end
		req_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("PASS quintic_min_jerk_coefficients");
		else
			$display("FAIL quintic_min_jerk_coefficients");
		$finish;
	end

endmodule

@@ quintic_min_jerk_coefficients.f @@
sv/qmj_pkg.sv
sv/qmj_ifs.sv
sv/qmj_front.sv
sv/qmj_fifo.sv
sv/qmj_back.sv
sv/quintic_min_jerk_coefficients.sv
tb/qmj_coef_checker.sv
tb/quintic_min_jerk_coefficients_tb.sv
